FILE: design/pct_pkg.sv
// Shared types, constants and helper functions of the port credit tracker.
`default_nettype none

package pct_pkg;

	// Sizes of the tracked state.
	localparam int NUM_PORTS      = 72;
	localparam int NUM_PRIORITIES = 8;

	// Field widths fixed by the stream format.
	localparam int OP_W    = 2;
	localparam int PORT_W  = 7;
	localparam int PRI_W   = 3;
	localparam int MODE_W  = 3;
	localparam int CNT_W   = 6;
	localparam int SUM_W   = 9;
	localparam int ERR_W   = 2;
	localparam int LIMIT_W = 6;
	localparam int MASK_W  = 8;

	// Derived sizes for the row store.
	localparam int ADDR_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int PRI_IDX_W = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Credit limits for each speed mode.
	localparam logic [MODE_W-1:0]  MODE_FAST   = 3'd7;
	localparam logic [MODE_W-1:0]  MODE_MEDIUM = 3'd6;
	localparam logic [MODE_W-1:0]  MODE_SLOW   = 3'd5;
	localparam logic [LIMIT_W-1:0] LIMIT_FAST    = 6'd32;
	localparam logic [LIMIT_W-1:0] LIMIT_MEDIUM  = 6'd16;
	localparam logic [LIMIT_W-1:0] LIMIT_SLOW    = 6'd8;
	localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = 6'd4;

	typedef enum logic [OP_W-1:0] {
		OP_CONSUME  = 2'd0,
		OP_RETURN   = 2'd1,
		OP_SET_MODE = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE       = 2'd0,
		ERR_OVER_LIMIT = 2'd1,
		ERR_UNDERFLOW  = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_SUM
	} state_t;

	// One input item as carried on the slave stream.
	typedef struct packed {
		logic [MODE_W-1:0] speed_mode;
		logic [PRI_W-1:0]  priority_req;
		logic [PORT_W-1:0] port;
		op_t               op;
	} item_t;

	// One row of the credit store: the speed mode and all counters of a port.
	typedef struct packed {
		logic [MODE_W-1:0]                     mode;
		logic [NUM_PRIORITIES-1:0][CNT_W-1:0] cnt;
	} row_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic read_row;
		logic update_row;
		logic load_result;
	} cmd_t;

	function automatic logic [LIMIT_W-1:0] speed_limit(input logic [MODE_W-1:0] mode);
		logic [LIMIT_W-1:0] lim;
		unique case (mode)
			MODE_FAST:   lim = LIMIT_FAST;
			MODE_MEDIUM: lim = LIMIT_MEDIUM;
			MODE_SLOW:   lim = LIMIT_SLOW;
			default:     lim = LIMIT_DEFAULT;
		endcase
		return lim;
	endfunction

endpackage

`default_nettype wire

FILE: design/port_credit_tracker.sv
// Top level of the port credit tracker: stream ports, controller and datapath.
//
//  Channel      Direction  Contents
//  s_*          in         item: op, port, priority_req, speed_mode
//  m_*          out        result: out_port, available, used_sum, error_code
//  pause_mask_* in         pause mask register write
//
// Each item passes through the transfer, the row read, the update with
// write-back, and the credit sum; a new item is taken only when idle.
// Reset clears the per-port row valid bits, so all counters and modes read as
// zero at once; there is no clearing pass.
// A result waiting in the output register does not block the next transfer;
// the sum step waits only when the output register is still full.
`default_nettype none

module port_credit_tracker
	import pct_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// op [1:0], port [8:2], priority_req [11:9], speed_mode [14:12]
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// out_port [6:0], available [7], used_sum [16:8], error_code [18:17]
	output logic [M_TDATA_W-1:0]      m_tdata,
	input  wire logic                 pause_mask_we,
	input  wire logic [MASK_W-1:0]    pause_mask_wdata
);

	cmd_t              cmd;
	item_t             item;
	logic [PORT_W-1:0] res_port;
	logic              res_available;
	logic [SUM_W-1:0]  res_used_sum;
	logic [ERR_W-1:0]  res_error;

	// Unpack the input item.
	assign item = item_t'(s_tdata[$bits(item_t)-1:0]);

	pct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	pct_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item          (item),
		.mask_we       (pause_mask_we),
		.mask_wdata    (pause_mask_wdata),
		.res_port      (res_port),
		.res_available (res_available),
		.res_used_sum  (res_used_sum),
		.res_error     (res_error)
	);

	// Pack the result, zero filled to whole bytes.
	assign m_tdata = {5'b0, res_error, res_used_sum, res_available, res_port};

endmodule

`default_nettype wire

FILE: design/pct_ctrl.sv
// Controller state machine that sequences one item through read, update and sum.
`default_nettype none

module pct_ctrl
	import pct_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The result register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_SUM;
			ST_SUM: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs to the datapath and the input handshake.
	always_comb begin
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			ST_READ:   cmd.read_row   = 1'b1;
			ST_UPDATE: cmd.update_row = 1'b1;
			ST_SUM:    cmd.load_result = out_free;
			default:   cmd = '0;
		endcase
	end

	// State and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: design/pct_dp.sv
// Datapath: item register, per-port credit row store, counter update and credit sum.
`default_nettype none

module pct_dp
	import pct_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire item_t             item,
	input  wire logic              mask_we,
	input  wire logic [MASK_W-1:0] mask_wdata,
	output logic [PORT_W-1:0]      res_port,
	output logic                   res_available,
	output logic [SUM_W-1:0]       res_used_sum,
	output logic [ERR_W-1:0]       res_error
);

	row_t                    mem [NUM_PORTS];
	logic [NUM_PORTS-1:0]    row_vld_q;
	logic [MASK_W-1:0]       pause_mask_q;

	item_t                   item_q;
	row_t                    rd_row_q;
	logic                    rd_vld_q;
	row_t                    upd_row_q;
	err_t                    upd_err_q;

	logic                    in_range;
	logic                    pri_ok;
	logic [ADDR_W-1:0]       addr;
	logic [PRI_IDX_W-1:0]    pri_idx;
	row_t                    cur_row;
	row_t                    new_row;
	err_t                    new_err;
	logic [CNT_W-1:0]        cnt;
	logic [LIMIT_W-1:0]      cur_limit;
	logic [SUM_W-1:0]        sum;
	logic [LIMIT_W-1:0]      sum_limit;

	assign in_range = {1'b0, item_q.port} < (PORT_W + 1)'(NUM_PORTS);
	assign pri_ok   = {1'b0, item_q.priority_req} < (PRI_W + 1)'(NUM_PRIORITIES);
	assign addr     = item_q.port[ADDR_W-1:0];
	assign pri_idx  = item_q.priority_req[PRI_IDX_W-1:0];

	// Pause mask register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_mask_q <= '0;
		end else if (mask_we) begin
			pause_mask_q <= mask_wdata;
		end
	end

	// Item register, loaded on the input transfer.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
	end

	// Row store read; the per-port valid bit makes a never-written row read as zero.
	always_ff @(posedge clk) begin
		if (cmd.read_row) begin
			rd_row_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q  <= 1'b0;
			row_vld_q <= '0;
		end else begin
			if (cmd.read_row) begin
				rd_vld_q <= in_range && row_vld_q[addr];
			end
			if (cmd.update_row && in_range) begin
				row_vld_q[addr] <= 1'b1;
			end
		end
	end

	assign cur_row   = rd_vld_q ? rd_row_q : '0;
	assign cur_limit = speed_limit(cur_row.mode);

	// Counter update or mode write for the item's port.
	always_comb begin
		new_row = cur_row;
		new_err = ERR_NONE;
		cnt     = cur_row.cnt[pri_idx];
		if (in_range) begin
			unique case (item_q.op)
				OP_SET_MODE: new_row.mode = item_q.speed_mode;
				OP_CONSUME: begin
					if (pri_ok) begin
						if (({1'b0, cnt} + 7'd1) > {1'b0, cur_limit}) begin
							new_err = ERR_OVER_LIMIT;
						end
						if (cnt != CNT_MAX) begin
							new_row.cnt[pri_idx] = cnt + 1'b1;
						end
					end
				end
				OP_RETURN: begin
					if (pri_ok) begin
						if (cnt == '0) begin
							new_err = ERR_UNDERFLOW;
						end else begin
							new_row.cnt[pri_idx] = cnt - 1'b1;
						end
					end
				end
				default: new_row = cur_row;
			endcase
		end
	end

	// Write back the updated row and keep it for the sum step.
	always_ff @(posedge clk) begin
		if (cmd.update_row) begin
			if (in_range) begin
				mem[addr] <= new_row;
			end
			upd_row_q <= new_row;
			upd_err_q <= new_err;
		end
	end

	// Sum of the counters whose priorities are not paused.
	always_comb begin
		sum = '0;
		for (int p = 0; p < NUM_PRIORITIES; p++) begin
			if (!pause_mask_q[p]) begin
				sum = sum + SUM_W'(upd_row_q.cnt[p]);
			end
		end
	end

	assign sum_limit = speed_limit(upd_row_q.mode);

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_port      <= item_q.port;
			res_available <= sum < SUM_W'(sum_limit);
			res_used_sum  <= sum;
			res_error     <= upd_err_q;
		end
	end

endmodule

`default_nettype wire

FILE: design/pct_checker.sv
// Port-level checks of the port credit tracker and their binding to the top level.
`default_nettype none

module pct_checker
	import pct_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	// A stalled result holds its data.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The block works on one item at a time after a transfer.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken during item processing");

	// A port beyond the table reports an empty port without error.
	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[6:0] >= 7'(NUM_PORTS))
		|-> m_tdata[16:8] == '0 && m_tdata[7] && m_tdata[18:17] == ERR_NONE)
		else $error("out-of-range port reported state");

	// No credits in use is always below any limit.
	a_empty_available: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16:8] == '0 |-> m_tdata[7])
		else $error("empty port reported unavailable");

endmodule

bind port_credit_tracker pct_checker u_pct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
